// ===== rtl/core/playback_fifo_with_prebuffer_core_defines.svh =====
// Assertion macros shared by the playback FIFO RTL.
`ifndef PLAYBACK_FIFO_WITH_PREBUFFER_CORE_DEFINES_SVH
`define PLAYBACK_FIFO_WITH_PREBUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define PFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define PFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pfp_pkg.sv =====
// Package with the widths, opcodes, state types and interface structs of the playback FIFO.
package pfp_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CAPACITY     = 8192;
    localparam int PTR_W        = $clog2(CAPACITY);
    localparam int LEVEL_W      = 16;
    localparam int DROP_W       = 32;
    localparam int SQ_W         = 31;
    localparam int SUM_W        = 43;
    localparam int CNT_W        = 13;
    localparam int MAX_BLOCK    = 4096;
    localparam int DIV_STEPS    = SUM_W;
    localparam int SQRT_STEPS   = 16;
    localparam int REM_W        = 20;
    localparam int OP_W         = 3;
    localparam int PREBUF_W     = 13;
    localparam int PREBUF_RESET = 2048;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 80;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_END   = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
    localparam logic [OP_W-1:0] OP_POP   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ACC,
        ST_LEVEL,
        ST_FINISH
    } pfp_state_t;

    typedef enum logic [1:0] {
        LV_IDLE,
        LV_DIV,
        LV_SQRT
    } lv_state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } lvl_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] root;
    } lvl_rsp_t;

endpackage

// ===== rtl/core/playback_fifo_with_prebuffer_core.sv =====
// Top level of the playback FIFO: ring memory, stream control sequencer and result register.
//
//  Channel   Direction  Payload
//  s_*       in         tuser: opcode[2:0]; tlast: block_last;
//                       tdata: sample_in[15:0], sink_playing[16]
//  m_*       out        tuser: sample_valid; tdata: sample_out, level, fill,
//                       dropped_count, is_playing, is_finished
//  cfg_*     in         prebuffer_samples, written whenever cfg_we is high
//
// A request passes through accept, execute and result load; a push also passes through the
// block sum. A push that closes a block then waits for the level unit: the 43-step divide,
// the 16-step square root and the hand-back of the root to the sequencer.
// s_tready is high only while the sequencer is idle.
// A result waits in the output register, so the next request can be taken while
// m_tvalid is still high. Reset is synchronous and needs no memory clearing pass.
module playback_fifo_with_prebuffer_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_in[15:0], sink_playing[16], zero pad[23:17]
    input  logic [pfp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // opcode[2:0]
    input  logic [pfp_pkg::OP_W-1:0]           s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sample_out[15:0], level[31:16], fill[44:32], dropped_count[76:45],
    // is_playing[77], is_finished[78], zero pad[79]
    output logic [pfp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // sample_valid[0]
    output logic                               m_tuser,
    input  logic                               cfg_we,
    input  logic [pfp_pkg::PREBUF_W-1:0]       cfg_wdata
);
    import pfp_pkg::*;

    `include "playback_fifo_with_prebuffer_core_defines.svh"

    pfp_state_t state_reg, state_next;

    // Captured request.
    logic [OP_W-1:0]            op_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       last_reg;
    logic                       sink_reg;

    // Stream state.
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic                started_reg, started_next;
    logic                playing_reg, playing_next;
    logic                active_reg, active_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [DROP_W-1:0]   drop_reg, drop_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [PREBUF_W-1:0] prebuf_reg;
    logic                rel_valid_reg, rel_valid_next;
    logic [SAMPLE_W-1:0] rel_sample_reg, rel_sample_next;

    // Result register.
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_user_reg;

    // Ring memory.
    logic [SAMPLE_W-1:0] ring_mem [CAPACITY];
    logic [SAMPLE_W-1:0] rdata_reg;
    logic                mem_we;

    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [PTR_W-1:0]    fill_w;
    logic [PTR_W-1:0]    fill_after;
    logic                gate_closed;
    logic [SUM_W-1:0]    acc_sum;
    logic [CNT_W-1:0]    acc_count;
    logic                accept;
    logic                out_load;
    logic                out_free;
    lvl_req_t            lvl_req;
    lvl_rsp_t            lvl_rsp;

    pfp_level_unit u_level (
        .aclk    (aclk),
        .aresetn (aresetn),
        .lvl_req (lvl_req),
        .lvl_rsp (lvl_rsp)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign fill_w   = wp_reg - rp_reg;
    assign sq_full  = sample_reg * sample_reg;

    // Closed while not started and the ring is empty, or below the prebuffer mark while streaming.
    assign gate_closed = !started_reg
                       && (((fill_w < prebuf_reg) && active_reg) || (fill_w == '0));
    assign fill_after  = (fill_w != '0) ? fill_w - 1'b1 : fill_w;

    // Overlong blocks stop adding once the count reaches the block limit.
    assign acc_sum   = (count_reg < CNT_W'(MAX_BLOCK)) ? sum_reg + SUM_W'(sq_reg) : sum_reg;
    assign acc_count = (count_reg < CNT_W'(MAX_BLOCK)) ? count_reg + 1'b1 : count_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC:   state_next = (op_reg == OP_PUSH) ? ST_ACC : ST_FINISH;
            ST_ACC:    state_next = (last_reg && acc_count != '0) ? ST_LEVEL : ST_FINISH;
            ST_LEVEL:  if (lvl_rsp.done) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready      = 1'b0;
        out_load      = 1'b0;
        lvl_req.start = 1'b0;
        lvl_req.sum   = acc_sum;
        lvl_req.count = acc_count;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_ACC:    lvl_req.start = last_reg && (acc_count != '0);
            ST_FINISH: out_load = out_free;
            default: ;
        endcase
    end

    // Stream state updates.
    always_comb begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        started_next    = started_reg;
        playing_next    = playing_reg;
        active_next     = active_reg;
        level_next      = level_reg;
        drop_next       = drop_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        sq_next         = sq_reg;
        rel_valid_next  = rel_valid_reg;
        rel_sample_next = rel_sample_reg;
        mem_we          = 1'b0;
        unique case (state_reg)
            ST_EXEC: begin
                rel_valid_next  = 1'b0;
                rel_sample_next = '0;
                unique case (op_reg)
                    OP_PUSH: begin
                        mem_we  = 1'b1;
                        sq_next = sq_full[SQ_W-1:0];
                        wp_next = wp_reg + 1'b1;
                        // A full ring loses its oldest sample.
                        if (wp_reg + 1'b1 == rp_reg) begin
                            rp_next = rp_reg + 1'b1;
                            if (drop_reg != '1) drop_next = drop_reg + 1'b1;
                        end
                    end
                    OP_START, OP_FLUSH: begin
                        wp_next      = '0;
                        rp_next      = '0;
                        started_next = 1'b0;
                        playing_next = 1'b0;
                        level_next   = '0;
                        sum_next     = '0;
                        count_next   = '0;
                        active_next  = (op_reg == OP_START);
                        if (op_reg == OP_START) drop_next = '0;
                    end
                    OP_END: active_next = 1'b0;
                    OP_POP: begin
                        if (!gate_closed) begin
                            started_next = 1'b1;
                            if (fill_w != '0) begin
                                rel_valid_next  = 1'b1;
                                rel_sample_next = rdata_reg;
                                rp_next         = rp_reg + 1'b1;
                                playing_next    = 1'b1;
                            end
                            // Drained and the speaker has gone quiet: back to idle.
                            if (fill_after == '0 && !sink_reg) begin
                                playing_next = 1'b0;
                                level_next   = '0;
                                started_next = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_ACC: begin
                if (last_reg) begin
                    sum_next   = '0;
                    count_next = '0;
                end else begin
                    sum_next   = acc_sum;
                    count_next = acc_count;
                end
            end
            ST_LEVEL: begin
                if (lvl_rsp.done) level_next = lvl_rsp.root;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            started_reg   <= 1'b0;
            playing_reg   <= 1'b0;
            active_reg    <= 1'b0;
            level_reg     <= '0;
            drop_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            prebuf_reg    <= PREBUF_W'(PREBUF_RESET);
            rel_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            started_reg   <= started_next;
            playing_reg   <= playing_next;
            active_reg    <= active_next;
            level_reg     <= level_next;
            drop_reg      <= drop_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            rel_valid_reg <= rel_valid_next;
            if (cfg_we) prebuf_reg <= cfg_wdata;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_tuser;
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            sink_reg   <= s_tdata[SAMPLE_W];
            last_reg   <= s_tlast;
        end
        sq_reg         <= sq_next;
        rel_sample_reg <= rel_sample_next;
        if (out_load) begin
            m_user_reg <= rel_valid_reg;
            m_data_reg <= {1'b0,
                           !active_reg && !playing_reg && (fill_w == '0),
                           playing_reg,
                           drop_reg,
                           fill_w,
                           level_reg,
                           rel_sample_reg};
        end
    end

    // The read port follows the read pointer every cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) ring_mem[wp_reg] <= sample_reg;
        rdata_reg <= ring_mem[rp_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `PFP_ASSERT_NOW(a_level_start_in_acc, lvl_req.start, state_reg == ST_ACC,
        "level unit started outside the accumulate step")
    `PFP_ASSERT_NEXT(a_push_leaves_data, (state_reg == ST_EXEC) && (op_reg == OP_PUSH),
        wp_reg != rp_reg, "ring empty right after a push")
    `PFP_ASSERT_NEXT(a_release_advances, (state_reg == ST_EXEC) && rel_valid_next,
        rp_reg == $past(rp_reg) + 1'b1, "released sample did not advance the read pointer")

endmodule

// ===== rtl/core/pfp_level_unit.sv =====
// Block level unit: restoring divide then integer square root on one shared subtractor.
module pfp_level_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  pfp_pkg::lvl_req_t lvl_req,
    output pfp_pkg::lvl_rsp_t lvl_rsp
);
    import pfp_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    lv_state_t          state_reg, state_next;
    logic [SUM_W-1:0]   dq_reg, dq_next;
    logic [CNT_W-1:0]   div_reg, div_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [LEVEL_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;

    logic [REM_W-1:0]   sub_a, sub_b;
    logic [REM_W:0]     sub_diff;
    logic               sub_ge;
    logic               div_last, sqrt_last;

    // The one subtractor: serves the divide and the root trial alike.
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[REM_W];

    assign div_last  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign sqrt_last = (step_reg == STEP_W'(SQRT_STEPS - 1));

    always_comb begin
        unique case (state_reg)
            LV_DIV: begin
                sub_a = {{(REM_W-CNT_W-1){1'b0}}, rem_reg[CNT_W-1:0], dq_reg[SUM_W-1]};
                sub_b = {{(REM_W-CNT_W){1'b0}}, div_reg};
            end
            LV_SQRT: begin
                sub_a = {rem_reg[REM_W-3:0], dq_reg[2*SQRT_STEPS-1:2*SQRT_STEPS-2]};
                sub_b = {{(REM_W-LEVEL_W-2){1'b0}}, root_reg, 2'b01};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            LV_IDLE: if (lvl_req.start) state_next = LV_DIV;
            LV_DIV:  if (div_last) state_next = LV_SQRT;
            LV_SQRT: if (sqrt_last) state_next = LV_IDLE;
            default: state_next = LV_IDLE;
        endcase
    end

    // Datapath updates driven by the state.
    always_comb begin
        dq_next   = dq_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        done_next = 1'b0;
        unique case (state_reg)
            LV_IDLE: begin
                if (lvl_req.start) begin
                    dq_next   = lvl_req.sum;
                    div_next  = lvl_req.count;
                    rem_next  = '0;
                    step_next = '0;
                end
            end
            LV_DIV: begin
                rem_next = sub_ge ? sub_diff[REM_W-1:0] : sub_a;
                dq_next  = {dq_reg[SUM_W-2:0], sub_ge};
                if (div_last) begin
                    rem_next  = '0;
                    root_next = '0;
                    step_next = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            LV_SQRT: begin
                rem_next  = sub_ge ? sub_diff[REM_W-1:0] : sub_a;
                root_next = {root_reg[LEVEL_W-2:0], sub_ge};
                dq_next   = {dq_reg[SUM_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                done_next = sqrt_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        dq_reg   <= dq_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
    end

    assign lvl_rsp.done = done_reg;
    assign lvl_rsp.root = root_reg;

endmodule

// ===== bench/pfp_checker.sv =====
// Checker for the playback FIFO: watches both streams, predicts each status word and compares.
`timescale 1ns / 100ps
module pfp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // sample_in[15:0], sink_playing[16], zero pad[23:17]
    input  logic [pfp_pkg::IN_TDATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  logic [pfp_pkg::OP_W-1:0]        s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // sample_out[15:0], level[31:16], fill[44:32], dropped_count[76:45],
    // is_playing[77], is_finished[78], zero pad[79]
    input  logic [pfp_pkg::OUT_TDATA_W-1:0] m_tdata,
    // sample_valid[0]
    input  logic                            m_tuser,
    input  logic                            cfg_we,
    input  logic [pfp_pkg::PREBUF_W-1:0]    cfg_wdata,
    output int                              err_count,
    output int                              pending
);
    import pfp_pkg::*;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
        logic [LEVEL_W-1:0]  level;
        logic [PTR_W-1:0]    fill;
        logic [DROP_W-1:0]   drops;
        logic                playing;
        logic                finished;
    } fifo_status_t;

    logic [SAMPLE_W-1:0] ring_mem [CAPACITY];
    logic [PTR_W-1:0]    wr_ptr;
    logic [PTR_W-1:0]    rd_ptr;
    logic                started;
    logic                playing;
    logic                streaming;
    logic [LEVEL_W-1:0]  level;
    logic [DROP_W-1:0]   drops;
    logic [PREBUF_W-1:0] prebuffer;
    longint unsigned     square_acc;
    longint unsigned     block_len;
    fifo_status_t        status_due[$];
    int                  results_seen;

    initial begin
        err_count    = 0;
        pending      = 0;
        results_seen = 0;
    end

    task automatic flag_error(input string msg);
        $display("[%0t] status #%0d: %s", $realtime, results_seen, msg);
        err_count++;
    endtask

    // Floor of the square root, one result bit at a time from the top.
    function automatic logic [LEVEL_W-1:0] rms_root(input longint unsigned mean_sq);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = LEVEL_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= mean_sq) begin
                root = trial;
            end
        end
        return root[LEVEL_W-1:0];
    endfunction

    task automatic clear_playback();
        wr_ptr     = '0;
        rd_ptr     = '0;
        started    = 1'b0;
        playing    = 1'b0;
        level      = '0;
        square_acc = 0;
        block_len  = 0;
    endtask

    task automatic apply_request(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                                 input logic last, input logic sink);
        fifo_status_t     st;
        logic [PTR_W-1:0] held;
        longint           sv;
        logic             gate_open;
        st = '0;
        case (op)
            OP_PUSH: begin
                sv = $signed(smp);
                // Samples past the block limit still go into the ring.
                if (block_len < MAX_BLOCK) begin
                    square_acc += sv * sv;
                    block_len++;
                end
                if (PTR_W'(wr_ptr + 1'b1) == rd_ptr) begin
                    rd_ptr++;
                    if (drops != '1) begin
                        drops++;
                    end
                end
                ring_mem[wr_ptr] = smp;
                wr_ptr++;
                if (last) begin
                    if (block_len != 0) begin
                        level = rms_root(square_acc / block_len);
                    end
                    square_acc = 0;
                    block_len  = 0;
                end
            end
            OP_START: begin
                clear_playback();
                streaming = 1'b1;
                drops     = '0;
            end
            OP_END: begin
                streaming = 1'b0;
            end
            OP_FLUSH: begin
                clear_playback();
                streaming = 1'b0;
            end
            OP_POP: begin
                held      = wr_ptr - rd_ptr;
                gate_open = 1'b1;
                if (!started) begin
                    if ((held < prebuffer && streaming) || held == 0) begin
                        gate_open = 1'b0;
                    end else begin
                        started = 1'b1;
                    end
                end
                if (gate_open) begin
                    if (held != 0) begin
                        st.valid  = 1'b1;
                        st.sample = ring_mem[rd_ptr];
                        rd_ptr++;
                        playing = 1'b1;
                    end
                    // Ring ran dry and the speaker is done: playback goes idle.
                    if (wr_ptr == rd_ptr && !sink) begin
                        playing = 1'b0;
                        level   = '0;
                        started = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        st.level    = level;
        st.fill     = wr_ptr - rd_ptr;
        st.drops    = drops;
        st.playing  = playing;
        st.finished = !streaming && !playing && wr_ptr == rd_ptr;
        status_due.push_back(st);
    endtask

    task automatic check_status();
        fifo_status_t want;
        results_seen++;
        if (status_due.size() == 0) begin
            flag_error("status word arrived with no request outstanding");
            return;
        end
        want = status_due.pop_front();
        if (m_tuser !== want.valid)
            flag_error($sformatf("sample_valid got %b want %b", m_tuser, want.valid));
        if (m_tdata[15:0] !== want.sample)
            flag_error($sformatf("sample_out got %h want %h", m_tdata[15:0], want.sample));
        if (m_tdata[31:16] !== want.level)
            flag_error($sformatf("level got %0d want %0d", m_tdata[31:16], want.level));
        if (m_tdata[44:32] !== want.fill)
            flag_error($sformatf("fill got %0d want %0d", m_tdata[44:32], want.fill));
        if (m_tdata[76:45] !== want.drops)
            flag_error($sformatf("dropped_count got %0d want %0d", m_tdata[76:45], want.drops));
        if (m_tdata[77] !== want.playing)
            flag_error($sformatf("is_playing got %b want %b", m_tdata[77], want.playing));
        if (m_tdata[78] !== want.finished)
            flag_error($sformatf("is_finished got %b want %b", m_tdata[78], want.finished));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CAPACITY; k++) begin
                ring_mem[k] = '0;
            end
            clear_playback();
            streaming = 1'b0;
            drops     = '0;
            prebuffer = PREBUF_W'(PREBUF_RESET);
            status_due.delete();
        end else begin
            // A status word can never belong to a request taken at the same edge.
            if (m_tvalid && m_tready) begin
                check_status();
            end
            if (cfg_we) begin
                prebuffer = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata[SAMPLE_W-1:0], s_tlast, s_tdata[SAMPLE_W]);
            end
        end
        pending = status_due.size();
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the playback FIFO: clock, reset, request and sink drivers, and the verdict.
`timescale 1ns / 100ps
module tb;
    import pfp_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_NOP_HI = 3'd7;
    localparam int SINK_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 80;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // sample_in[15:0], sink_playing[16], zero pad[23:17]
    logic [IN_TDATA_W-1:0]  s_tdata;
    // opcode[2:0]
    logic [OP_W-1:0]        s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    // sample_out[15:0], level[31:16], fill[44:32], dropped_count[76:45],
    // is_playing[77], is_finished[78], zero pad[79]
    logic [OUT_TDATA_W-1:0] m_tdata;
    // sample_valid[0]
    logic                   m_tuser;
    logic                   cfg_we;
    logic [PREBUF_W-1:0]    cfg_wdata;

    int err_count;
    int pending;
    int requests_sent  = 0;
    int settings_used  = 0;
    bit quiet          = 1'b0;
    bit sink_hold_req  = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    playback_fifo_with_prebuffer_core DUT (.*);

    pfp_checker u_checker (.*);

    function automatic int idle_cycles();
        return quiet ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offers one request from a falling edge and returns at the falling edge after acceptance.
    task automatic send(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                        input logic last, input logic sink);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {{(IN_TDATA_W - SAMPLE_W - 1){1'b0}}, sink, smp};
        s_tlast  = last;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic set_prebuffer(input logic [PREBUF_W-1:0] value);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we    = 1'b0;
        settings_used++;
    endtask

    task automatic pop(input logic sink);
        send(OP_POP, pick_sample(), coin(), sink);
    endtask

    // One stream from start to end with random content, plus some stray control traffic.
    task automatic play_session(input int budget);
        int sent;
        int blk;
        int roll;
        int i;
        send(OP_START, pick_sample(), coin(), coin());
        sent = 1;
        while (sent < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                blk = $urandom_range(1, 10);
                for (i = 0; i < blk; i++) begin
                    send(OP_PUSH, pick_sample(), i == blk - 1, coin());
                end
                sent += blk;
            end else if (roll < 85) begin
                pop($urandom_range(0, 3) != 0);
                sent++;
            end else if (roll < 90) begin
                send(OP_END, pick_sample(), coin(), coin());
                sent++;
            end else if (roll < 93) begin
                send(OP_FLUSH, pick_sample(), coin(), coin());
                sent++;
            end else if (roll < 96) begin
                send(OP_START, pick_sample(), coin(), coin());
                sent++;
            end else begin
                send(OP_W'($urandom_range(OP_NOP_LO, OP_NOP_HI)), pick_sample(),
                     coin(), coin());
                sent++;
            end
        end
        // Close the stream and play out part or all of what is left.
        send(OP_END, pick_sample(), coin(), coin());
        repeat ($urandom_range(4, 24)) pop($urandom_range(0, 3) != 0);
    endtask

    task automatic random_phase(input int target);
        int pb;
        while (requests_sent < target) begin
            drain();
            case ($urandom_range(0, 7))
                0: pb = 0;
                1: pb = $urandom_range(0, 8191);
                default: pb = $urandom_range(1, 24);
            endcase
            set_prebuffer(PREBUF_W'(pb));
            quiet = ($urandom_range(0, 3) == 0);
            play_session($urandom_range(20, 120));
        end
        quiet = 1'b0;
    endtask

    // Sink side: a fresh stall per status word, or one long hold when asked for.
    initial begin : sink_driver
        int gap;
        m_tready = 1'b0;
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                gap = SINK_HOLD;
            end else begin
                gap = idle_cycles();
            end
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_PUSH;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed opening: gate, level extremes, idle clear, leftover drain and flush.
        set_prebuffer(3);
        send(OP_POP, 16'h1234, 1'b0, 1'b0);
        send(OP_NOP_LO, 16'hFFFF, 1'b1, 1'b1);
        send(OP_NOP_HI, 16'h0000, 1'b0, 1'b0);
        send(OP_START, 16'h0000, 1'b0, 1'b0);
        send(OP_PUSH, 16'h7FFF, 1'b0, 1'b0);
        send(OP_PUSH, 16'h8000, 1'b1, 1'b1);
        send(OP_POP, 16'h0000, 1'b0, 1'b1);
        send(OP_PUSH, 16'h0000, 1'b1, 1'b0);
        send(OP_POP, 16'h5A5A, 1'b1, 1'b1);
        send(OP_POP, 16'hA5A5, 1'b0, 1'b1);
        send(OP_POP, 16'h0000, 1'b0, 1'b1);
        // Empty ring with the speaker busy keeps playing; once it is idle, playback stops.
        send(OP_POP, 16'h0000, 1'b0, 1'b1);
        send(OP_POP, 16'h0000, 1'b0, 1'b0);
        send(OP_END, 16'hFFFF, 1'b1, 1'b1);
        send(OP_PUSH, 16'h0001, 1'b1, 1'b0);
        send(OP_POP, 16'h0000, 1'b0, 1'b0);
        send(OP_PUSH, 16'hFFFF, 1'b1, 1'b1);
        send(OP_FLUSH, 16'h0000, 1'b0, 1'b0);
        send(OP_POP, 16'h0000, 1'b0, 1'b0);
        drain();
        set_prebuffer(0);
        send(OP_START, 16'h0000, 1'b0, 1'b0);
        send(OP_PUSH, 16'h8000, 1'b0, 1'b1);
        send(OP_POP, 16'h0000, 1'b0, 1'b1);
        send(OP_END, 16'h0000, 1'b0, 1'b0);
        send(OP_POP, 16'h0000, 1'b0, 1'b0);

        random_phase(requests_sent + 850);

        // Hold the sink off while requests keep coming, so the core backs up.
        drain();
        set_prebuffer(2);
        quiet = 1'b1;
        sink_hold_req = 1'b1;
        play_session(60);
        quiet = 1'b0;

        random_phase(requests_sent + 850);

        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Summary: %0d requests checked over %0d gate settings,",
                 requests_sent, settings_used);
        $display("with random streams, stray opcodes and a %0d-cycle sink hold.", SINK_HOLD);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("Timeout: requests or status words stopped moving.");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pfp_pkg.sv
rtl/core/pfp_level_unit.sv
rtl/core/playback_fifo_with_prebuffer_core.sv
bench/pfp_checker.sv
bench/tb.sv
